/* src/i8sq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package i8sq_pkg;

  // fp32 constants
  localparam logic [31:0] FP_ONE   = 32'h3F80_0000;  // 1.0
  localparam logic [31:0] FP_TINY  = 32'h2B8C_BCCC;  // 1e-12
  localparam logic [7:0]  EXP_127  = 8'd133;         // exponent field of 127.0
  localparam logic [23:0] MAN_127  = 24'hFE_0000;    // significand of 127.0, hidden bit set
  localparam logic [7:0]  EXP_INF  = 8'hFF;
  localparam logic [6:0]  CODE_MAX = 7'd127;

  // request to the shared divider
  typedef struct packed {
    logic        start;
    logic [7:0]  num_exp;
    logic [23:0] num_man;
    logic [7:0]  den_exp;
    logic [23:0] den_man;
  } div_req_t;

  // divider answer
  typedef struct packed {
    logic        done;
    logic [31:0] bits;
  } div_rsp_t;

endpackage

`default_nettype wire

/* src/int8_symmetric_quantizer.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel | handshake            | payload
// in      | in_valid / in_stall  | value_bits, last_element
// out     | out_valid / out_stall| code, scale_bits, last_code, overflowed
//
// load: one element per cycle while in_stall is low.
// after the last element, two fp32 divisions on the shared restoring divider
// give scale and 127/max; then each buffered element passes through ram read,
// multiply, round and output, and stays at output while out_stall is high.
// in_stall stays high from the last element until the final code is taken.
// rst is synchronous and clears control state; the element store is not cleared.

module int8_symmetric_quantizer #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [31:0]       value_bits,
  input  logic              last_element,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [7:0] code,
  output logic [31:0]       scale_bits,
  output logic              last_code,
  output logic              overflowed
);

  import i8sq_pkg::*;

  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  typedef enum logic [8:0] {
    S_LOAD = 9'b0_0000_0001,
    S_SCL  = 9'b0_0000_0010,
    S_SCLW = 9'b0_0000_0100,
    S_INV  = 9'b0_0000_1000,
    S_INVW = 9'b0_0001_0000,
    S_READ = 9'b0_0010_0000,
    S_MUL  = 9'b0_0100_0000,
    S_QNT  = 9'b0_1000_0000,
    S_OUT  = 9'b1_0000_0000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic [31:0]      largest;
  logic             dropped;
  logic [31:0]      inv;

  logic             in_req;
  logic             out_req;
  logic             room;
  logic [31:0]      mag;
  logic [31:0]      amax;
  logic [31:0]      rd_data;
  logic signed [7:0] q_code;
  logic             is_last;
  div_req_t         dreq;
  div_rsp_t         drsp;

  assign in_req  = in_valid && !in_stall;
  assign out_req = out_valid && !out_stall;
  assign room    = count < CNT_W'(MAX_ELEMENTS);
  assign mag     = {1'b0, value_bits[30:0]};
  assign amax    = (largest < FP_TINY) ? FP_ONE : largest;
  assign is_last = (idx + CNT_W'(1)) == count;

  assign in_stall  = (state != S_LOAD);
  assign out_valid = (state == S_OUT);

  // element store
  i8sq_ram #(
    .WIDTH (32),
    .DEPTH (MAX_ELEMENTS)
  ) u_ram (
    .clk   (clk),
    .we    (in_req && room),
    .waddr (count[ADDR_W-1:0]),
    .wdata (value_bits),
    .raddr (idx[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  // divider requests: max/127 first, then 127/max
  always_comb begin
    dreq = '0;
    if (state == S_SCL) begin
      dreq.start   = 1'b1;
      dreq.num_exp = amax[30:23];
      dreq.num_man = {1'b1, amax[22:0]};
      dreq.den_exp = EXP_127;
      dreq.den_man = MAN_127;
    end else if (state == S_INV) begin
      dreq.start   = 1'b1;
      dreq.num_exp = EXP_127;
      dreq.num_man = MAN_127;
      dreq.den_exp = amax[30:23];
      dreq.den_man = {1'b1, amax[22:0]};
    end
  end

  i8sq_fdiv u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  i8sq_quant u_quant (
    .clk        (clk),
    .load       (state == S_MUL),
    .value_bits (rd_data),
    .inv_bits   (inv),
    .code       (q_code)
  );

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_LOAD: if (in_req && last_element) state_next = S_SCL;
      S_SCL:  state_next = S_SCLW;
      S_SCLW: if (drsp.done) state_next = S_INV;
      S_INV:  state_next = S_INVW;
      S_INVW: if (drsp.done) state_next = S_READ;
      S_READ: state_next = S_MUL;
      S_MUL:  state_next = S_QNT;
      S_QNT:  state_next = S_OUT;
      S_OUT: begin
        if (out_stall) begin
          state_next = S_OUT;
        end else if (last_code) begin
          state_next = S_LOAD;
        end else begin
          state_next = S_READ;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LOAD;
      count   <= '0;
      idx     <= '0;
      largest <= '0;
      dropped <= 1'b0;
    end else begin
      state <= state_next;
      if (in_req) begin
        if (room) begin
          count <= count + CNT_W'(1);
          if ((mag[30:23] != EXP_INF) && (mag > largest)) begin
            largest <= mag;
          end
        end else begin
          dropped <= 1'b1;
        end
      end
      if (state == S_INVW) begin
        idx <= '0;
      end
      if (out_req) begin
        if (last_code) begin
          count   <= '0;
          largest <= '0;
          dropped <= 1'b0;
        end else begin
          idx <= idx + CNT_W'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if ((state == S_SCLW) && drsp.done) begin
      scale_bits <= drsp.bits;
    end
    if ((state == S_INVW) && drsp.done) begin
      inv <= drsp.bits;
    end
    if (state == S_QNT) begin
      code       <= q_code;
      last_code  <= is_last;
      overflowed <= dropped;
    end
  end

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && !in_stall))
    else $error("input taken while a result is pending");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ELEMENTS))
    else $error("element count beyond capacity");

  a_code_sym: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (code != -8'sd128))
    else $error("code outside symmetric range");

  a_back_to_load: assert property (@(posedge clk) disable iff (rst)
    (out_req && last_code) |=> (!in_stall && (count == '0)))
    else $error("not ready for next tensor after final code");

endmodule

`default_nettype wire

/* src/i8sq_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module i8sq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/i8sq_fdiv.sv */
`timescale 1ns / 1ps
`default_nettype none

module i8sq_fdiv (
  input  logic                clk,
  input  logic                rst,
  input  i8sq_pkg::div_req_t  req,
  output i8sq_pkg::div_rsp_t  rsp
);

  import i8sq_pkg::*;

  logic        busy;
  logic        fin;
  logic [4:0]  cnt;
  logic [25:0] rem;
  logic [23:0] den;
  logic [24:0] quo;
  logic [9:0]  exp_acc;
  logic        done_r;
  logic [31:0] bits_r;

  logic        lt;
  logic        ge;
  logic [25:0] diff;
  logic        up;
  logic [24:0] mant;
  logic [9:0]  exp_fin;

  // operand compare picks the quotient range [1,2)
  assign lt   = req.num_man < req.den_man;
  // one restoring step
  assign ge   = rem >= {2'b00, den};
  assign diff = ge ? (rem - {2'b00, den}) : rem;
  // round to nearest even: guard bit is quo[0], sticky is the remainder
  assign up      = quo[0] & ((rem != 26'd0) | quo[1]);
  assign mant    = {1'b0, quo[24:1]} + {24'd0, up};
  assign exp_fin = exp_acc + {9'd0, mant[24]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      fin    <= 1'b0;
      done_r <= 1'b0;
      cnt    <= 5'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
      end else if (busy) begin
        if (cnt == 5'd24) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end else begin
          cnt <= cnt + 5'd1;
        end
      end else if (fin) begin
        fin    <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= lt ? {1'b0, req.num_man, 1'b0} : {2'b00, req.num_man};
      den     <= req.den_man;
      exp_acc <= {2'b00, req.num_exp} - {2'b00, req.den_exp} + 10'd127 - {9'd0, lt};
    end else if (busy) begin
      rem <= {diff[24:0], 1'b0};
      quo <= {quo[23:0], ge};
    end
    if (fin) begin
      bits_r <= {1'b0, exp_fin[7:0], mant[22:0]};
    end
  end

  assign rsp.done = done_r;
  assign rsp.bits = bits_r;

endmodule

`default_nettype wire

/* src/i8sq_quant.sv */
`timescale 1ns / 1ps
`default_nettype none

module i8sq_quant (
  input  logic              clk,
  input  logic              load,
  input  logic [31:0]       value_bits,
  input  logic [31:0]       inv_bits,
  output logic signed [7:0] code
);

  import i8sq_pkg::*;

  logic [47:0] prod;
  logic [8:0]  esum;
  logic        neg;
  logic        skip;

  logic        s;
  logic [23:0] m_pre;
  logic        g;
  logic        st;
  logic        up;
  logic [24:0] msum;
  logic [23:0] m;
  logic [10:0] e2;
  logic [10:0] kneg;
  logic [4:0]  k;
  logic [23:0] sh1;
  logic [22:0] intp;
  logic [6:0]  q;

  // significand product, registered
  always_ff @(posedge clk) begin
    if (load) begin
      prod <= {1'b1, value_bits[22:0]} * {1'b1, inv_bits[22:0]};
      esum <= {1'b0, value_bits[30:23]} + {1'b0, inv_bits[30:23]};
      neg  <= value_bits[31];
      // zero, subnormal and non-finite values all give zero
      skip <= (value_bits[30:23] == 8'd0) || (value_bits[30:23] == EXP_INF);
    end
  end

  // round product to fp32
  assign s     = prod[47];
  assign m_pre = s ? prod[47:24] : prod[46:23];
  assign g     = s ? prod[23] : prod[22];
  assign st    = s ? (|prod[22:0]) : (|prod[21:0]);
  assign up    = g & (st | m_pre[0]);
  assign msum  = {1'b0, m_pre} + {24'd0, up};
  assign m     = msum[24] ? 24'h80_0000 : msum[23:0];

  // value is m * 2^e2
  assign e2   = {2'b00, esum} + {10'd0, s} + {10'd0, msum[24]} - 11'd277;
  assign kneg = 11'd0 - e2;
  assign k    = kneg[4:0];
  assign sh1  = m >> (k - 5'd1);
  assign intp = sh1[23:1];

  // round half away, clamp
  always_comb begin
    if (!e2[10]) begin
      q = CODE_MAX;
    end else if (e2 < 11'd2024) begin
      q = 7'd0;
    end else if (intp >= {16'd0, CODE_MAX}) begin
      q = CODE_MAX;
    end else begin
      q = intp[6:0] + {6'd0, sh1[0]};
    end
  end

  assign code = skip ? 8'sd0 : (neg ? -$signed({1'b0, q}) : $signed({1'b0, q}));

endmodule

`default_nettype wire
